// File: design/cubic_trajectory_sampler_defines.svh
// ----------------------------------------------------------------------------
// Cubic trajectory sampler assertion macros
// Property checks used by the sampler; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef CUBIC_TRAJECTORY_SAMPLER_DEFINES_SVH
`define CUBIC_TRAJECTORY_SAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/ctsmp_pkg.sv
// ----------------------------------------------------------------------------
// Cubic trajectory sampler package
// Shared widths, codes, unit request/response types and saturation helpers.
// ----------------------------------------------------------------------------
package ctsmp_pkg;

    localparam int MUL_W     = 36;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_CNT_W = $clog2(MUL_W + 1);
    localparam int NUM_W     = 70;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int POS_W     = 32;
    localparam int VEL_W     = 48;
    localparam int ACC_W     = 64;
    localparam int SAMPLE_W  = 16;
    localparam int DUR_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X  = 3'd0,
        REG_START_Y  = 3'd1,
        REG_START_Z  = 3'd2,
        REG_END_X    = 3'd3,
        REG_END_Y    = 3'd4,
        REG_END_Z    = 3'd5,
        REG_DURATION = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_U   = 3'd0,
        OP_NN  = 3'd1,
        OP_U2  = 3'd2,
        OP_U3  = 3'd3,
        OP_Q   = 3'd4,
        OP_POS = 3'd5,
        OP_VEL = 3'd6,
        OP_ACC = 3'd7
    } op_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [VEL_W-1:0] sat_vel(input logic neg, input logic [NUM_W-1:0] mag);
        logic [NUM_W-1:0] lim;
        logic [NUM_W-1:0] v;
        lim = NUM_W'(1) << (VEL_W - 1);
        if (neg)
        begin
            v = (mag > lim) ? (NUM_W'(0) - lim) : (NUM_W'(0) - mag);
        end
        else
        begin
            v = (mag > lim - NUM_W'(1)) ? (lim - NUM_W'(1)) : mag;
        end
        return v[VEL_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] sat_acc(input logic neg, input logic [NUM_W-1:0] mag);
        logic [NUM_W-1:0] lim;
        logic [NUM_W-1:0] v;
        lim = NUM_W'(1) << (ACC_W - 1);
        if (neg)
        begin
            v = (mag > lim) ? (NUM_W'(0) - lim) : (NUM_W'(0) - mag);
        end
        else
        begin
            v = (mag > lim - NUM_W'(1)) ? (lim - NUM_W'(1)) : mag;
        end
        return v[ACC_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [35:0] p);
        logic [POS_W-1:0] v;
        if (p > 36'sh0_7FFF_FFFF)
        begin
            v = 32'h7FFF_FFFF;
        end
        else if (p < -36'sh0_8000_0000)
        begin
            v = 32'h8000_0000;
        end
        else
        begin
            v = p[POS_W-1:0];
        end
        return v;
    endfunction

endpackage

// File: design/ctsmp_mul.sv
// ----------------------------------------------------------------------------
// Cubic trajectory sampler serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ctsmp_mul
    import ctsmp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [MUL_W-1:0]     a_reg;
    logic [2*MUL_W:0]     p_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [MUL_W:0]       sum;

    // add multiplicand into the high half when the low bit is set
    assign sum = p_reg[2*MUL_W:MUL_W] + (p_reg[0] ? {1'b0, a_reg} : {(MUL_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= MUL_CNT_W'(MUL_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - MUL_CNT_W'(1);
                done_reg <= (cnt_reg == MUL_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            p_reg <= {{(MUL_W+1){1'b0}}, req.b};
        end
        else if (cnt_reg != '0)
        begin
            p_reg <= {1'b0, sum, p_reg[MUL_W-1:1]};
        end
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign rsp.prod = p_reg[PROD_W-1:0];

endmodule

// File: design/ctsmp_div.sv
// ----------------------------------------------------------------------------
// Cubic trajectory sampler serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctsmp_div
    import ctsmp_pkg::*;
#(
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  div_req_t      req,
    input  logic [DW-1:0] divisor,
    output div_rsp_t      rsp
);

    logic [DW-1:0]        d_reg;
    logic [DW-1:0]        rem_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [DW:0]          trial;
    logic [DW:0]          diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= DIV_CNT_W'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
                done_reg <= (cnt_reg == DIV_CNT_W'(1));
            end
        end
    end

    // quotient bits shift in behind the numerator
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            d_reg   <= divisor;
            rem_reg <= '0;
            num_reg <= req.num;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            num_reg <= {num_reg[NUM_W-2:0], ge};
        end
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

// File: design/cubic_trajectory_sampler.sv
// ----------------------------------------------------------------------------
// Cubic trajectory sampler
// Point-to-point cubic setpoints with zero end velocities, three axes.
// ----------------------------------------------------------------------------
// A transaction on the input with restart set latches the start point, the
// per-axis distance and the length N from the configuration registers and
// produces sample 0; each later transaction with restart clear produces the
// next sample until sample N-1, which is flagged by last_sample. A
// transaction that arrives while no trajectory is running (or with N of zero)
// produces no result. Position, velocity per step and acceleration per step
// squared come from one bit-serial multiplier and one bit-serial restoring
// divider shared by all axes: each sample takes 13 multiplier passes and 7
// divider passes. One sample is worked on at a time; the next transaction
// is accepted while a finished result waits on the output.
// Configuration writes take effect at the next restart.
// ----------------------------------------------------------------------------
`include "cubic_trajectory_sampler_defines.svh"

module cubic_trajectory_sampler
    import ctsmp_pkg::*;
#(
    parameter int INDEX_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]       cfg_data,
    // tick input
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    restart,
    // sample output
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic signed [POS_W-1:0] pos_z,
    output logic signed [VEL_W-1:0] vel_x,
    output logic signed [VEL_W-1:0] vel_y,
    output logic signed [VEL_W-1:0] vel_z,
    output logic signed [ACC_W-1:0] acc_x,
    output logic signed [ACC_W-1:0] acc_y,
    output logic signed [ACC_W-1:0] acc_z,
    output logic [SAMPLE_W-1:0]     sample_number,
    output logic                    last_sample
);

    localparam int W  = INDEX_WIDTH;
    // divisor width covers N, N << 16 and N * N
    localparam int DW = (2 * W > W + 16) ? 2 * W : W + 16;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    // configuration registers
    logic signed [POS_W-1:0] start_reg [3];
    logic signed [POS_W-1:0] end_reg [3];
    logic [DUR_W-1:0]        dur_reg;

    // trajectory control
    state_t        state_reg;
    op_t           op_reg;
    logic [1:0]    axis_reg;
    logic          running_reg;
    logic [W-1:0]  idx_reg;
    logic [W-1:0]  len_reg;
    logic          mul_go_reg;
    logic          div_go_reg;
    logic          out_valid_reg;

    // latched axis coefficients (written at restart only)
    logic signed [POS_W-1:0] s_reg [3];
    logic                    dneg_reg [3];
    logic [32:0]             dmag_reg [3];

    // per-sample working values
    logic [W-1:0]      i_reg;
    logic [31:0]       u_reg;
    logic [32:0]       u2_reg;
    logic [32:0]       u3_reg;
    logic [32:0]       q_reg;
    logic [DW-1:0]     nn_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [POS_W-1:0]  pos_w_reg [3];
    logic [VEL_W-1:0]  vel_w_reg [3];
    logic [ACC_W-1:0]  acc_w_reg [3];

    // output register
    logic [POS_W-1:0]    pos_o_reg [3];
    logic [VEL_W-1:0]    vel_o_reg [3];
    logic [ACC_W-1:0]    acc_o_reg [3];
    logic [SAMPLE_W-1:0] num_o_reg;
    logic                last_o_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic [DW-1:0] div_d;

    logic          in_fire;
    logic [W-1:0]  len_new;
    logic          eff_run;
    logic [W-1:0]  eff_idx;
    logic [W-1:0]  eff_len;
    logic          go;
    logic [W:0]    eff_next;
    logic          last_w;
    logic          out_load;

    logic [34:0]       h;
    logic [34:0]       m;
    logic [35:0]       u12;
    logic              cneg;
    logic [35:0]       cmag;
    logic [PROD_W-1:0] prod_rnd;
    logic [39:0]       off_full;
    logic [34:0]       off_clamp;
    logic signed [35:0] s_ext;
    logic signed [35:0] off_ext;
    logic signed [35:0] pos_sum;

    // -------------------------------------------------------------------------
    // configuration port: always ready, writes land at once
    // -------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                start_reg[k] <= '0;
                end_reg[k]   <= '0;
            end
            dur_reg <= DUR_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_X:  start_reg[0] <= cfg_data;
                REG_START_Y:  start_reg[1] <= cfg_data;
                REG_START_Z:  start_reg[2] <= cfg_data;
                REG_END_X:    end_reg[0]   <= cfg_data;
                REG_END_Y:    end_reg[1]   <= cfg_data;
                REG_END_Z:    end_reg[2]   <= cfg_data;
                REG_DURATION: dur_reg      <= cfg_data[DUR_W-1:0];
                default:      ;
            endcase
        end
    end

    // -------------------------------------------------------------------------
    // tick decode: restart reloads the run, otherwise advance when running
    // -------------------------------------------------------------------------
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign len_new  = W'(dur_reg);
    assign eff_run  = restart ? (len_new != '0) : running_reg;
    assign eff_idx  = restart ? '0 : idx_reg;
    assign eff_len  = restart ? len_new : len_reg;
    assign go       = eff_run && (eff_idx < eff_len);
    assign eff_next = {1'b0, eff_idx} + (W+1)'(1);
    assign last_w   = (({1'b0, i_reg} + (W+1)'(1)) == {1'b0, len_reg});

    // -------------------------------------------------------------------------
    // shape terms derived from u, u^2, u^3 and u(1-u)
    // -------------------------------------------------------------------------
    assign h    = {1'b0, u2_reg, 1'b0} + {2'b00, u2_reg} - {1'b0, u3_reg, 1'b0};
    assign m    = {q_reg, 2'b00} + {1'b0, q_reg, 1'b0};
    assign u12  = {2'b00, u_reg, 2'b00} + {1'b0, u_reg, 3'b000};
    assign cneg = (u12 > {4'd6, 32'd0});
    assign cmag = cneg ? (u12 - {4'd6, 32'd0}) : ({4'd6, 32'd0} - u12);

    // rounded Q.32 product and position offset
    assign prod_rnd  = mul_rsp.prod + (PROD_W'(1) << 31);
    assign off_full  = prod_rnd[71:32];
    assign off_clamp = (off_full > (40'd1 << 34)) ? (35'd1 << 34) : off_full[34:0];
    assign s_ext     = {{4{s_reg[axis_reg][31]}}, s_reg[axis_reg]};
    assign off_ext   = {1'b0, off_clamp};
    assign pos_sum   = dneg_reg[axis_reg] ? (s_ext - off_ext) : (s_ext + off_ext);

    // -------------------------------------------------------------------------
    // shared arithmetic units and their operand selection
    // -------------------------------------------------------------------------
    always_comb
    begin
        mul_req.start = mul_go_reg;
        case (op_reg)
            OP_NN:
            begin
                mul_req.a = MUL_W'(len_reg);
                mul_req.b = MUL_W'(len_reg);
            end
            OP_U2:
            begin
                mul_req.a = MUL_W'(u_reg);
                mul_req.b = MUL_W'(u_reg);
            end
            OP_U3:
            begin
                mul_req.a = MUL_W'(u2_reg);
                mul_req.b = MUL_W'(u_reg);
            end
            OP_Q:
            begin
                mul_req.a = MUL_W'(u_reg);
                mul_req.b = MUL_W'({1'b1, 32'd0} - {1'b0, u_reg});
            end
            OP_POS:
            begin
                mul_req.a = MUL_W'(dmag_reg[axis_reg]);
                mul_req.b = MUL_W'(h);
            end
            OP_VEL:
            begin
                mul_req.a = MUL_W'(dmag_reg[axis_reg]);
                mul_req.b = MUL_W'(m);
            end
            OP_ACC:
            begin
                mul_req.a = MUL_W'(dmag_reg[axis_reg]);
                mul_req.b = MUL_W'(cmag);
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_req.start = div_go_reg;
        case (op_reg)
            OP_U:    div_d = DW'(len_reg);
            OP_VEL:  div_d = DW'(len_reg) << 16;
            default: div_d = nn_reg;
        endcase
        // numerator carries the rounding half of the divisor
        case (op_reg)
            OP_U:    div_req.num = (NUM_W'(i_reg) << 32) | NUM_W'(len_reg >> 1);
            default: div_req.num = NUM_W'(prod_reg) + NUM_W'(div_d >> 1);
        endcase
    end

    ctsmp_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    ctsmp_div #(
        .DW (DW)
    ) u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (div_d),
        .rsp     (div_rsp)
    );

    // -------------------------------------------------------------------------
    // sequencer: u, N*N, u^2, u^3, u(1-u), then position, velocity and
    // acceleration for each axis in turn
    // -------------------------------------------------------------------------
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_U;
            axis_reg      <= '0;
            running_reg   <= 1'b0;
            idx_reg       <= '0;
            len_reg       <= '0;
            mul_go_reg    <= 1'b0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (restart)
                        begin
                            len_reg <= len_new;
                        end
                        idx_reg     <= go ? eff_next[W-1:0] : eff_idx;
                        running_reg <= go && (eff_next < {1'b0, eff_len});
                        if (go)
                        begin
                            state_reg  <= ST_DIV;
                            op_reg     <= OP_U;
                            div_go_reg <= 1'b1;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (mul_rsp.done)
                    begin
                        case (op_reg)
                            OP_NN:
                            begin
                                op_reg     <= OP_U2;
                                mul_go_reg <= 1'b1;
                            end
                            OP_U2:
                            begin
                                op_reg     <= OP_U3;
                                mul_go_reg <= 1'b1;
                            end
                            OP_U3:
                            begin
                                op_reg     <= OP_Q;
                                mul_go_reg <= 1'b1;
                            end
                            OP_Q:
                            begin
                                op_reg     <= OP_POS;
                                axis_reg   <= '0;
                                mul_go_reg <= 1'b1;
                            end
                            OP_POS:
                            begin
                                op_reg     <= OP_VEL;
                                mul_go_reg <= 1'b1;
                            end
                            default:
                            begin
                                state_reg  <= ST_DIV;
                                div_go_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        case (op_reg)
                            OP_U:
                            begin
                                state_reg  <= ST_MUL;
                                op_reg     <= OP_NN;
                                mul_go_reg <= 1'b1;
                            end
                            OP_VEL:
                            begin
                                state_reg  <= ST_MUL;
                                op_reg     <= OP_ACC;
                                mul_go_reg <= 1'b1;
                            end
                            default:
                            begin
                                if (axis_reg == 2'd2)
                                begin
                                    state_reg <= ST_OUT;
                                end
                                else
                                begin
                                    state_reg  <= ST_MUL;
                                    op_reg     <= OP_POS;
                                    axis_reg   <= axis_reg + 2'd1;
                                    mul_go_reg <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // -------------------------------------------------------------------------
    // datapath registers: coefficients, working values, output payload
    // -------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire && restart)
        begin
            // latch start point and distance magnitude/sign per axis
            for (int k = 0; k < 3; k++)
            begin
                logic signed [32:0] d;
                d = {end_reg[k][31], end_reg[k]} - {start_reg[k][31], start_reg[k]};
                s_reg[k]    <= start_reg[k];
                dneg_reg[k] <= d[32];
                dmag_reg[k] <= d[32] ? (33'd0 - d) : d;
            end
        end
        if (in_fire && go)
        begin
            i_reg <= eff_idx;
        end
        if (state_reg == ST_DIV && div_rsp.done)
        begin
            case (op_reg)
                OP_U:    u_reg <= div_rsp.quo[31:0];
                OP_VEL:  vel_w_reg[axis_reg] <= sat_vel(dneg_reg[axis_reg], div_rsp.quo);
                default: acc_w_reg[axis_reg] <= sat_acc(dneg_reg[axis_reg] != cneg && cmag != '0,
                                                        div_rsp.quo);
            endcase
        end
        if (state_reg == ST_MUL && mul_rsp.done)
        begin
            case (op_reg)
                OP_NN:   nn_reg <= DW'(mul_rsp.prod);
                OP_U2:   u2_reg <= prod_rnd[64:32];
                OP_U3:   u3_reg <= prod_rnd[64:32];
                OP_Q:    q_reg  <= prod_rnd[64:32];
                OP_POS:  pos_w_reg[axis_reg] <= sat_pos(pos_sum);
                default: prod_reg <= mul_rsp.prod;
            endcase
        end
        if (out_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pos_o_reg[k] <= pos_w_reg[k];
                vel_o_reg[k] <= vel_w_reg[k];
                acc_o_reg[k] <= acc_w_reg[k];
            end
            num_o_reg  <= SAMPLE_W'(i_reg);
            last_o_reg <= last_w;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pos_x         = pos_o_reg[0];
    assign pos_y         = pos_o_reg[1];
    assign pos_z         = pos_o_reg[2];
    assign vel_x         = vel_o_reg[0];
    assign vel_y         = vel_o_reg[1];
    assign vel_z         = vel_o_reg[2];
    assign acc_x         = acc_o_reg[0];
    assign acc_y         = acc_o_reg[1];
    assign acc_z         = acc_o_reg[2];
    assign sample_number = num_o_reg;
    assign last_sample   = last_o_reg;

    // -------------------------------------------------------------------------
    // assertions
    // -------------------------------------------------------------------------
    // the shared units never run at the same time
    `CTS_ASSERT_IMPL(a_units_exclusive, clk, rst_n, mul_rsp.busy, !div_rsp.busy, "mul and div overlap")
    // a finished sample leaves the run open exactly when it is not the last one
    `CTS_ASSERT_IMPL(a_last_vs_run, clk, rst_n, state_reg == ST_OUT, running_reg != last_w, "last flag disagrees with run state")
    // a restart with a nonzero length always starts the sequencer
    `CTS_ASSERT_NEXT(a_restart_starts, clk, rst_n, in_fire && restart && len_new != '0, state_reg == ST_DIV, "restart did not start")

endmodule
